// File: hw/rtl/vfd_pkg.sv
package vfd_pkg;

  localparam int unsigned MAX_FRAME = 16384;

  localparam logic [14:0] CAP_RESET = 15'd16384;

  localparam logic [2:0] VARINT_LAST_INDEX = 3'd4;
  localparam logic [2:0] VARINT_BYTES      = 3'd5;

  localparam logic [7:0] MARKER_PLAIN     = 8'h00;
  localparam logic [7:0] MARKER_ENCRYPTED = 8'h01;

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_ENCRYPTED  = 3'd0;
  localparam logic [2:0] ERR_BAD_MARKER = 3'd1;
  localparam logic [2:0] ERR_BAD_VARINT = 3'd2;
  localparam logic [2:0] ERR_ZERO_TYPE  = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd4;

  typedef enum logic [1:0] {
    PH_MARKER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_TYPE   = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [31:0] frame_type;
    logic [14:0] frame_length;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/varint_frame_deframer.sv
// Length-prefixed frame parser: takes one received byte per cycle while in_stall is low
// and gives at most one word per byte (header, body byte or error). A byte is held in
// the input register on accept, decoded as it advances, and its word is captured in the
// output register. Stall on the output propagates to in_stall in the same cycle. The user
// must write capacity through cfg_wr_en/cfg_wr_data while the block is idle; the block
// does not enforce this. capacity resets to 16384.
module varint_frame_deframer
  import vfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  body_byte,
  output logic [31:0] frame_type,
  output logic [14:0] frame_length,
  output logic [2:0]  error_code,
  output logic        last
);

  logic [14:0] capacity;
  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        out_free;
  logic        advance;
  logic        accept_in;
  logic        res_valid;
  result_t     res;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_reg_valid && out_free;
  assign in_stall  = in_reg_valid && !out_free;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept_in) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) in_reg_byte <= in_byte;
  end

  vfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_reg_byte),
    .capacity  (capacity),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind     <= res.kind;
      body_byte    <= res.body_byte;
      frame_type   <= res.frame_type;
      frame_length <= res.frame_length;
      error_code   <= res.error_code;
      last         <= res.last;
    end
  end

  // an error word never carries data or a last mark
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |-> !last && body_byte == 8'd0 && frame_type == 32'd0)
    else $error("error word carries payload");

  // a header always has a nonzero type and a length within the frame limit
  a_header_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_HEADER |->
      frame_type != 32'd0 && 32'(frame_length) <= 32'(MAX_FRAME) && frame_length <= capacity)
    else $error("header out of range");

  // an empty frame's header is the only header marked last
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_HEADER |-> last == (frame_length == 15'd0))
    else $error("header last mark mismatch");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind != 2'd3 && (out_kind == KIND_ERROR || error_code == 3'd0))
    else $error("bad kind or stray error code");

endmodule

// File: hw/rtl/vfd_parser.sv
module vfd_parser
  import vfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic [14:0] capacity,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [2:0]  varint_index, varint_index_next;
  logic [31:0] varint_accum, varint_accum_next;
  logic [31:0] held_length, held_length_next;
  logic [14:0] body_remaining, body_remaining_next;

  logic [4:0]  shift;
  logic [31:0] accum_or;
  logic [2:0]  index_inc;
  logic        cont;
  logic        nib_bad;
  logic        overflow;
  logic        type_zero;
  logic        too_large;
  logic [14:0] rem_dec;
  logic        fin;

  assign shift     = 5'({2'b00, varint_index} * 5'd7);
  assign accum_or  = varint_accum | (32'(in_byte[6:0]) << shift);
  assign index_inc = varint_index + 3'd1;
  assign cont      = in_byte[7];
  assign nib_bad   = (varint_index == VARINT_LAST_INDEX) && (in_byte[7:4] != 4'd0);
  assign overflow  = cont && (index_inc >= VARINT_BYTES);
  assign type_zero = (accum_or == 32'd0);
  assign too_large = (held_length > 32'(MAX_FRAME)) || (held_length > {17'd0, capacity});
  assign rem_dec   = (body_remaining != 15'd0) ? body_remaining - 15'd1 : body_remaining;
  assign fin       = (rem_dec == 15'd0);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_MARKER: begin
        if (in_byte == MARKER_PLAIN) phase_next = PH_LENGTH;
      end
      PH_BODY: begin
        if (fin) phase_next = PH_MARKER;
      end
      PH_LENGTH, PH_TYPE: begin
        if (nib_bad || overflow) begin
          phase_next = PH_MARKER;
        end else if (!cont) begin
          if (phase == PH_LENGTH) begin
            phase_next = PH_TYPE;
          end else if (type_zero || too_large || held_length == 32'd0) begin
            phase_next = PH_MARKER;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      default: phase_next = PH_MARKER;
    endcase
  end

  always_comb begin
    varint_index_next   = varint_index;
    varint_accum_next   = varint_accum;
    held_length_next    = held_length;
    body_remaining_next = body_remaining;
    res_valid           = 1'b0;
    res                 = '0;
    unique case (phase)
      PH_MARKER: begin
        varint_index_next = 3'd0;
        varint_accum_next = 32'd0;
        if (in_byte != MARKER_PLAIN) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = (in_byte == MARKER_ENCRYPTED) ? ERR_ENCRYPTED : ERR_BAD_MARKER;
        end
      end
      PH_BODY: begin
        body_remaining_next = rem_dec;
        res_valid           = 1'b1;
        res.kind            = KIND_BODY;
        res.body_byte       = in_byte;
        res.last            = fin;
      end
      PH_LENGTH, PH_TYPE: begin
        if (nib_bad || overflow) begin
          varint_index_next = 3'd0;
          varint_accum_next = 32'd0;
          res_valid         = 1'b1;
          res.kind          = KIND_ERROR;
          res.error_code    = ERR_BAD_VARINT;
        end else if (cont) begin
          varint_index_next = index_inc;
          varint_accum_next = accum_or;
        end else begin
          varint_index_next = 3'd0;
          varint_accum_next = 32'd0;
          if (phase == PH_LENGTH) begin
            held_length_next = accum_or;
          end else begin
            res_valid = 1'b1;
            if (type_zero) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_ZERO_TYPE;
            end else if (too_large) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TOO_LARGE;
            end else begin
              res.kind         = KIND_HEADER;
              res.frame_type   = accum_or;
              res.frame_length = held_length[14:0];
              res.last         = (held_length == 32'd0);
              if (held_length != 32'd0) body_remaining_next = held_length[14:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MARKER;
      varint_index   <= 3'd0;
      varint_accum   <= 32'd0;
      held_length    <= 32'd0;
      body_remaining <= 15'd0;
    end else if (step) begin
      phase          <= phase_next;
      varint_index   <= varint_index_next;
      varint_accum   <= varint_accum_next;
      held_length    <= held_length_next;
      body_remaining <= body_remaining_next;
    end
  end

endmodule
